// ===== design/mrt_pkg.sv =====
package mrt_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int BASE_W   = 64;
    localparam int LEN_W    = 64;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int FLAG_W   = 2;
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 136;

    // Operation codes carried on the slave tuser
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the input word, clear result flags
        logic add;         // append the input range if there is room
        logic rd_idx;      // read the table at the requested index
        logic set_bad;     // flag an out-of-range read
        logic rd_capture;  // hold the read data as the result
        logic rd_walk;     // read the entry under the walk pointer
        logic load;        // form lo and hi of the fetched entry
        logic trim;        // cut head and tail against the removed range
        logic split;       // check for a hole, form the piece lengths
        logic wr_keep;     // write back the kept piece, advance the walk
        logic wr_app;      // append the upper piece of a split
        logic walk_end;    // drop squeezed entries from the count
        logic publish;     // load the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic walk_more;   // walk pointer below the entry count
        logic idx_ok;      // read index below the entry count
        logic split;       // current entry has a hole in the middle
        logic out_free;    // output register can take a word
    } stat_t;

endpackage

// ===== design/mrt_ram.sv =====
module mrt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mrt_datapath.sv =====
module mrt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrt_pkg::cmd_t               cmd,
    output mrt_pkg::stat_t              stat,
    input  logic [mrt_pkg::BASE_W-1:0]  in_base,
    input  logic [mrt_pkg::LEN_W-1:0]   in_length,
    input  logic [mrt_pkg::IDX_W-1:0]   in_index,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [mrt_pkg::BASE_W-1:0]  out_base,
    output logic [mrt_pkg::LEN_W-1:0]   out_length,
    output logic [mrt_pkg::COUNT_W-1:0] out_count,
    output logic                        out_dropped,
    output logic                        out_bad
);
    import mrt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int RW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int EW = BASE_W + LEN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Input word
    logic [BASE_W-1:0] cut_lo_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BASE_W-1:0] cut_hi_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Counters
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;

    // Walk pipeline
    logic [BASE_W-1:0] lo_reg, lo_next;
    logic [BASE_W-1:0] hi_reg, hi_next;
    logic [LEN_W-1:0]  keep_len_reg, keep_len_next;
    logic [LEN_W-1:0]  up_len_reg, up_len_next;
    logic              split_reg, split_next;
    logic              skip_reg, skip_next;

    // Result
    logic [BASE_W-1:0] res_base_reg, res_base_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic              lost_reg, lost_next;
    logic              bad_reg, bad_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [BASE_W-1:0]  out_base_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_dropped_reg;
    logic               out_bad_reg;

    // Table memory
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rdata;
    logic [BASE_W-1:0] rd_base;
    logic [LEN_W-1:0]  rd_len;

    logic          full;
    logic          keep_nz;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] count_xi;
    logic [RW-1:0] count_xo;

    // Trim compares
    logic c_a, c_b, c_c, c_d, c_f, c_g, cl_gt_lo1;
    logic [BASE_W-1:0] lo1, hi1;
    logic [LEN_W-1:0]  d_keep, d_cut, d_up;
    logic              sp;

    mrt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_base  = rdata[BASE_W-1:0];
    assign rd_len   = rdata[EW-1:BASE_W];
    assign full     = (count_reg >= DEPTH_C);
    assign keep_nz  = (keep_len_reg != '0);
    assign idx_x    = XW'(idx_reg);
    assign count_xi = XW'(count_reg);
    assign count_xo = RW'(count_reg);

    // Memory port steering
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = {len_reg, cut_lo_reg};
        if (cmd.add && !full)
        begin
            we = 1'b1;
        end
        if (cmd.wr_keep && keep_nz)
        begin
            we    = 1'b1;
            waddr = k_reg[AW-1:0];
            wdata = {keep_len_reg, lo_reg};
        end
        if (cmd.wr_app && !full)
        begin
            we    = 1'b1;
            wdata = {up_len_reg, cut_hi_reg};
        end
        re    = cmd.rd_idx || cmd.rd_walk;
        raddr = cmd.rd_idx ? idx_x[AW-1:0] : i_reg[AW-1:0];
    end

    // Head and tail trim; all compares use the untrimmed lo and hi
    always_comb
    begin
        c_a = (cut_hi_reg <= lo_reg);
        c_b = (cut_lo_reg >= hi_reg);
        c_c = (cut_lo_reg <= lo_reg);
        c_d = (cut_hi_reg < hi_reg);
        c_f = (cut_lo_reg > cut_hi_reg);
        c_g = (cut_lo_reg > hi_reg);
        lo1 = c_c ? (c_d ? cut_hi_reg : hi_reg) : lo_reg;
        cl_gt_lo1 = c_c ? (c_d ? c_f : c_g) : 1'b1;
        hi1 = c_d ? hi_reg : (cl_gt_lo1 ? cut_lo_reg : lo1);
    end

    // Hole check and piece lengths; an entry the cut misses is never split
    always_comb
    begin
        sp     = !skip_reg && (cut_lo_reg > lo_reg) && (cut_hi_reg < hi_reg);
        d_keep = hi_reg - lo_reg;
        d_cut  = cut_lo_reg - lo_reg;
        d_up   = hi_reg - cut_hi_reg;
    end

    always_comb
    begin
        count_next    = count_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        keep_len_next = keep_len_reg;
        up_len_next   = up_len_reg;
        split_next    = split_reg;
        skip_next     = skip_reg;
        res_base_next = res_base_reg;
        res_len_next  = res_len_reg;
        lost_next     = lost_reg;
        bad_next      = bad_reg;

        if (cmd.capture)
        begin
            i_next        = '0;
            k_next        = '0;
            res_base_next = '0;
            res_len_next  = '0;
            lost_next     = 1'b0;
            bad_next      = 1'b0;
        end
        if (cmd.add || cmd.wr_app)
        begin
            if (full)
            begin
                lost_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.set_bad)
        begin
            bad_next = 1'b1;
        end
        if (cmd.rd_capture)
        begin
            res_base_next = rd_base;
            res_len_next  = rd_len;
        end
        if (cmd.load)
        begin
            lo_next = rd_base;
            hi_next = rd_base + rd_len;
        end
        if (cmd.trim)
        begin
            skip_next = c_a || c_b;
            if (!(c_a || c_b))
            begin
                lo_next = lo1;
                hi_next = hi1;
            end
        end
        if (cmd.split)
        begin
            split_next    = sp;
            keep_len_next = sp ? d_cut : d_keep;
            up_len_next   = d_up;
        end
        if (cmd.wr_keep)
        begin
            i_next = i_reg + 1'b1;
            if (keep_nz)
            begin
                k_next = k_reg + 1'b1;
            end
        end
        if (cmd.walk_end)
        begin
            count_next = k_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cut_lo_reg <= in_base;
            len_reg    <= in_length;
            cut_hi_reg <= in_base + in_length;
            idx_reg    <= in_index;
        end
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        keep_len_reg <= keep_len_next;
        up_len_reg   <= up_len_next;
        split_reg    <= split_next;
        skip_reg     <= skip_next;
        res_base_reg <= res_base_next;
        res_len_reg  <= res_len_next;
        lost_reg     <= lost_next;
        bad_reg      <= bad_next;
        if (cmd.publish)
        begin
            out_base_reg    <= res_base_reg;
            out_len_reg     <= res_len_reg;
            out_count_reg   <= count_xo[COUNT_W-1:0];
            out_dropped_reg <= lost_reg;
            out_bad_reg     <= bad_reg;
        end
    end

    assign stat.walk_more = (i_reg < count_reg);
    assign stat.idx_ok    = (idx_x < count_xi);
    assign stat.split     = split_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_base    = out_base_reg;
    assign out_length  = out_len_reg;
    assign out_count   = out_count_reg;
    assign out_dropped = out_dropped_reg;
    assign out_bad     = out_bad_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_pack_behind_walk: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= i_reg)
        else $error("compaction pointer ahead of walk pointer");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> stat.out_free)
        else $error("result overwrote an untaken word");

endmodule

// ===== design/mrt_ctrl.sv =====
module mrt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [mrt_pkg::MODE_W-1:0] in_mode,
    output logic                       in_ready,
    output mrt_pkg::cmd_t              cmd,
    input  mrt_pkg::stat_t             stat
);
    import mrt_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_ADD    = 13'b0000000000010,
        ST_RREQ   = 13'b0000000000100,
        ST_RWAIT  = 13'b0000000001000,
        ST_WCHK   = 13'b0000000010000,
        ST_WLD    = 13'b0000000100000,
        ST_WTRIM  = 13'b0000001000000,
        ST_WSPLIT = 13'b0000010000000,
        ST_WWR    = 13'b0000100000000,
        ST_WAPP   = 13'b0001000000000,
        ST_DONE   = 13'b0010000000000,
        ST_RSKIP  = 13'b0100000000000,
        ST_WEND   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_mode)
                        MODE_ADD:    state_next = ST_ADD;
                        MODE_REMOVE: state_next = ST_WCHK;
                        MODE_READ:   state_next = ST_RREQ;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_DONE;
            end
            ST_RREQ:
            begin
                if (stat.idx_ok)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = ST_RWAIT;
                end
                else
                begin
                    state_next = ST_RSKIP;
                end
            end
            ST_RSKIP:
            begin
                cmd.set_bad = 1'b1;
                state_next  = ST_DONE;
            end
            ST_RWAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_WCHK:
            begin
                if (stat.walk_more)
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = ST_WLD;
                end
                else
                begin
                    state_next = ST_WEND;
                end
            end
            ST_WLD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_WTRIM;
            end
            ST_WTRIM:
            begin
                cmd.trim   = 1'b1;
                state_next = ST_WSPLIT;
            end
            ST_WSPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = ST_WWR;
            end
            ST_WWR:
            begin
                cmd.wr_keep = 1'b1;
                state_next  = stat.split ? ST_WAPP : ST_WCHK;
            end
            ST_WAPP:
            begin
                cmd.wr_app = 1'b1;
                state_next = ST_WCHK;
            end
            ST_WEND:
            begin
                cmd.walk_end = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in flight");

    a_publish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (state_reg == ST_IDLE))
        else $error("controller not idle after publishing");

    a_split_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_keep && stat.split) |=> cmd.wr_app)
        else $error("split piece not appended after write-back");

endmodule

// ===== design/memory_region_table.sv =====
// Result path: an add passes the add state, a read the request and then the wait or skip state,
//   mode 3 goes straight to done, and a remove walks every entry (splitting holes) before done.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result is loaded into the output register, paced by the controller sequence.
// Reset clears the entry count and all control state; table contents stay
//   undefined and need no clearing pass, since only slots below the count are read.
module memory_region_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Slave side
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // range_base[63:0], range_length[127:64], entry_index[131:128], zero fill above
    input  logic [mrt_pkg::S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [mrt_pkg::MODE_W-1:0]   s_axis_tuser,
    // Master side
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // region_base[63:0], region_length[127:64], region_count[132:128], zero fill above
    output logic [mrt_pkg::M_DATA_W-1:0] m_axis_tdata,
    // dropped[0], bad_index[1]
    output logic [mrt_pkg::FLAG_W-1:0]   m_axis_tuser
);
    import mrt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [BASE_W-1:0]  in_base;
    logic [LEN_W-1:0]   in_length;
    logic [IDX_W-1:0]   in_index;

    logic [BASE_W-1:0]  out_base;
    logic [LEN_W-1:0]   out_length;
    logic [COUNT_W-1:0] out_count;
    logic               out_dropped;
    logic               out_bad;

    // Unpack the incoming word
    assign in_base   = s_axis_tdata[BASE_W-1:0];
    assign in_length = s_axis_tdata[BASE_W+LEN_W-1:BASE_W];
    assign in_index  = s_axis_tdata[BASE_W+LEN_W+IDX_W-1:BASE_W+LEN_W];

    // The controller sequences one operation at a time: an add is a single
    // RAM write, a read is a RAM access plus one wait state, and a remove walks
    // every entry (read, form ends, trim, hole check, write back, append of a split's upper piece) while packing
    // surviving entries downward in the same pass, so no second sweep is needed.
    mrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath owns the table RAM, the count, the walk and pack pointers,
    // the trim arithmetic and the output register. The output register lets a
    // new word be taken while the previous result still waits downstream.
    mrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_base     (in_base),
        .in_length   (in_length),
        .in_index    (in_index),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_base    (out_base),
        .out_length  (out_length),
        .out_count   (out_count),
        .out_dropped (out_dropped),
        .out_bad     (out_bad)
    );

    // Pack the result word; fill bits stay zero
    assign m_axis_tdata = {{(M_DATA_W - BASE_W - LEN_W - COUNT_W){1'b0}},
                           out_count, out_length, out_base};
    assign m_axis_tuser = {out_bad, out_dropped};

endmodule

// ===== test/memory_region_table_tb.sv =====
module memory_region_table_tb;

    import mrt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int N_RANDOM    = 1880;
    localparam int N_CALM      = 200;   // final stretch with no idling on either side
    localparam int DRAIN_WAIT  = 150;   // longer than a remove that walks a full table

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;   // unused code, table left as it is, a plain result word returned
    localparam logic [63:0]       ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    // One result word, split into its fields
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] count;
        logic               dropped;
        logic               bad;
    } region_word_t;

    // One row of the directed table; reps repeats the same word
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        int                reps;
        bit                typed;
        region_word_t      want;
    } stim_row_t;

    localparam int N_DIRECTED = 14;

    // Rows with typed results can be read off the spec directly; the rest go through
    // the table model below.
    stim_row_t directed_rows [0:N_DIRECTED-1] = '{
        // read on an empty table
        '{MODE_READ, 64'd0, 64'd0, 4'd0, 1, 1'b1, '{64'd0, 64'd0, 5'd0, 1'b0, 1'b1}},
        // unused mode with every data bit set
        '{MODE_NONE, ALL_ONES, ALL_ONES, 4'd15, 1, 1'b1,
          '{64'd0, 64'd0, 5'd0, 1'b0, 1'b0}},
        // largest length at address zero
        '{MODE_ADD, 64'd0, ALL_ONES, 4'd0, 1, 1'b1, '{64'd0, 64'd0, 5'd1, 1'b0, 1'b0}},
        // zero length at the top address, kept until a remove
        '{MODE_ADD, ALL_ONES, 64'd0, 4'd0, 1, 1'b1, '{64'd0, 64'd0, 5'd2, 1'b0, 1'b0}},
        '{MODE_READ, 64'd0, 64'd0, 4'd0, 1, 1'b1, '{64'd0, ALL_ONES, 5'd2, 1'b0, 1'b0}},
        '{MODE_READ, 64'd0, 64'd0, 4'd1, 1, 1'b1, '{ALL_ONES, 64'd0, 5'd2, 1'b0, 1'b0}},
        // read past the count
        '{MODE_READ, 64'd0, 64'd0, 4'd15, 1, 1'b1, '{64'd0, 64'd0, 5'd2, 1'b0, 1'b1}},
        // hole in the big entry: split, zero-length entry squeezed out
        '{MODE_REMOVE, 64'h10, 64'h10, 4'd0, 1, 1'b0, '0},
        // cut whose end wraps past the top of the address space
        '{MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, 4'd0, 1, 1'b0, '0},
        // entry whose own end wraps
        '{MODE_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 4'd0, 1, 1'b0, '0},
        // fill the table up
        '{MODE_ADD, 64'h1_0000_0000, 64'h1000, 4'd0, 12, 1'b0, '0},
        // add to a full table
        '{MODE_ADD, 64'h5000, 64'h100, 4'd0, 1, 1'b1, '{64'd0, 64'd0, 5'd16, 1'b1, 1'b0}},
        // hole in many entries with no room for the upper pieces
        '{MODE_REMOVE, 64'h1_0000_0400, 64'h100, 4'd0, 1, 1'b0, '0},
        // wipe nearly the whole address space, clearing the table
        '{MODE_REMOVE, 64'd0, ALL_ONES, 4'd0, 1, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // range_base[63:0], range_length[127:64], entry_index[131:128], zero fill above
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    // mode[1:0]
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // region_base[63:0], region_length[127:64], region_count[132:128], zero fill above
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // dropped[0], bad_index[1]
    logic [FLAG_W-1:0]     m_axis_tuser;

    // Table model: entries below entry_count are live
    logic [BASE_W-1:0] entry_base [TABLE_DEPTH];
    logic [LEN_W-1:0]  entry_len  [TABLE_DEPTH];
    int unsigned       entry_count = 0;

    region_word_t expected_regions [$];
    int           mismatch_count = 0;
    bit           sender_idle    = 1'b1;
    bit           receiver_idle  = 1'b1;
    int           stall_left     = 0;
    logic [63:0]  window_base;

    memory_region_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cut [cut_lo, cut_lo + cut_len) out of every live entry, then squeeze out
    // zero-length entries in order. Return 1 if an upper piece found no room.
    function automatic bit carve_out(input logic [63:0] cut_lo, input logic [63:0] cut_len);
        logic [63:0] cut_hi;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          lost;
        int unsigned kept;
        cut_hi = cut_lo + cut_len;
        lost   = 1'b0;
        // pieces appended here are walked too, so the bound is re-read each pass
        for (int unsigned i = 0; i < entry_count; i++)
        begin
            lo = entry_base[i];
            hi = entry_base[i] + entry_len[i];
            if (cut_hi <= lo || cut_lo >= hi)
                continue;
            if (cut_lo <= lo)
                lo = (cut_hi < hi) ? cut_hi : hi;
            if (cut_hi >= hi)
                hi = (cut_lo > lo) ? cut_lo : lo;
            if (cut_lo > lo && cut_hi < hi)
            begin
                if (entry_count < TABLE_DEPTH)
                begin
                    entry_base[entry_count] = cut_hi;
                    entry_len[entry_count]  = hi - cut_hi;
                    entry_count++;
                end
                else
                    lost = 1'b1;
                hi = cut_lo;
            end
            entry_base[i] = lo;
            entry_len[i]  = hi - lo;
        end
        kept = 0;
        for (int unsigned i = 0; i < entry_count; i++)
        begin
            if (entry_len[i] != 0)
            begin
                entry_base[kept] = entry_base[i];
                entry_len[kept]  = entry_len[i];
                kept++;
            end
        end
        entry_count = kept;
        return lost;
    endfunction

    // Apply one accepted word to the table model and return the word the block owes
    function automatic region_word_t region_table_step(input logic [MODE_W-1:0] mode,
                                                       input logic [63:0] base,
                                                       input logic [63:0] len,
                                                       input logic [IDX_W-1:0] idx);
        region_word_t r;
        r = '0;
        case (mode)
            MODE_ADD:
            begin
                if (entry_count >= TABLE_DEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    entry_base[entry_count] = base;
                    entry_len[entry_count]  = len;
                    entry_count++;
                end
            end
            MODE_REMOVE:
                r.dropped = carve_out(base, len);
            MODE_READ:
            begin
                if (idx < entry_count)
                begin
                    r.base = entry_base[idx];
                    r.len  = entry_len[idx];
                end
                else
                    r.bad = 1'b1;
            end
            default: ;
        endcase
        r.count = entry_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    // Offer one word, hold it until accepted, then queue what it should produce.
    // A typed row supplies its own expectation; the model still tracks the table.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [63:0] base,
                             input logic [63:0] len, input logic [IDX_W-1:0] idx,
                             input bit typed, input region_word_t want);
        int           gap;
        region_word_t predicted;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, idx, len, base};
        s_axis_tuser  <= mode;
        // values sampled here are the ones seen by the edge itself
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = region_table_step(mode, base, len, idx);
        expected_regions.push_back(typed ? want : predicted);
    endtask

    // Random word: mostly adds and removes inside a small address window so that
    // entries overlap, touch and split; some reads, some unused-mode and raw noise,
    // and now and then a wipe that empties the table and moves the window.
    task automatic random_word();
        logic [MODE_W-1:0] mode;
        logic [63:0]       base;
        logic [63:0]       len;
        logic [IDX_W-1:0]  idx;
        int                pick;
        pick = $urandom_range(0, 99);
        mode = MODE_READ;
        base = {$urandom, $urandom};
        len  = {$urandom, $urandom};
        idx  = IDX_W'($urandom_range(0, 15));
        if (pick < 35)
        begin
            mode = MODE_ADD;
            base = window_base + (64'($urandom_range(0, 63)) << 6);
            len  = 64'($urandom_range(0, 16)) << 6;
        end
        else if (pick < 60)
        begin
            mode = MODE_REMOVE;
            base = window_base + (64'($urandom_range(0, 63)) << 6)
                   + ($urandom_range(0, 2) == 0 ? 64'($urandom_range(1, 63)) : 64'd0);
            len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095))
                                               : 64'($urandom_range(0, 12)) << 6;
        end
        else if (pick < 85)
        begin
            // mostly live slots, sometimes past the count
            if (entry_count != 0 && $urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, entry_count - 1));
        end
        else if (pick < 89)
            mode = MODE_NONE;
        else if (pick < 96)
            mode = MODE_W'($urandom_range(0, 3));
        else
        begin
            mode        = MODE_REMOVE;
            base        = 64'd0;
            len         = ALL_ONES;
            window_base = {$urandom, $urandom} & 64'hFFFF_FFFF_FFF0_0000;
        end
        send_word(mode, base, len, idx, 1'b0, '0);
    endtask

    // Result side: check every accepted word against the oldest expectation, then
    // pick the ready level for the next edge (stalls come in bursts of random length).
    always @(posedge clk)
    begin
        region_word_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_regions.size() == 0)
                report("word with nothing expected", m_axis_tdata[63:0], 64'd0);
            else
            begin
                want = expected_regions.pop_front();
                if (m_axis_tdata[63:0] !== want.base)
                    report("region_base", m_axis_tdata[63:0], want.base);
                if (m_axis_tdata[127:64] !== want.len)
                    report("region_length", m_axis_tdata[127:64], want.len);
                if (m_axis_tdata[132:128] !== want.count)
                    report("region_count", 64'(m_axis_tdata[132:128]), 64'(want.count));
                if (m_axis_tuser[0] !== want.dropped)
                    report("dropped", 64'(m_axis_tuser[0]), 64'(want.dropped));
                if (m_axis_tuser[1] !== want.bad)
                    report("bad_index", 64'(m_axis_tuser[1]), 64'(want.bad));
            end
        end
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (rst_n && receiver_idle && m_axis_tready && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        window_base = {$urandom, $urandom} & 64'hFFFF_FFFF_FFF0_0000;

        // directed rows first
        foreach (directed_rows[r])
        begin
            for (int n = 0; n < directed_rows[r].reps; n++)
                send_word(directed_rows[r].mode, directed_rows[r].base, directed_rows[r].len,
                          directed_rows[r].idx, directed_rows[r].typed, directed_rows[r].want);
        end

        // hold the sender until every owed word is back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_regions.size() != 0)
            @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // re-roll idling per stretch, so some stretches run flat out
            if (n % 100 == 0)
            begin
                sender_idle   = ($urandom_range(0, 3) != 0);
                receiver_idle = ($urandom_range(0, 3) != 0);
            end
            if (n >= N_RANDOM - N_CALM)
            begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            random_word();
        end

        // drain, then give any stray word time to show up
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_regions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
